FILE: hw/rtl/polar_obstacle_histogram_defines.svh
// Assertion macros used by the polar histogram back end.
`ifndef POLAR_OBSTACLE_HISTOGRAM_DEFINES_SVH
`define POLAR_OBSTACLE_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
`define POH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define POH_NEVER(lbl, cond, msg) `POH_ASSERT(lbl, !(cond), msg)
`else
`define POH_ASSERT(lbl, prop, msg)
`define POH_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/poh_pkg.sv
// Shared types, constants and helper functions of the polar histogram.
package poh_pkg;

    localparam int SECTORS      = 72;
    localparam int SEC_W        = $clog2(SECTORS);
    localparam int CNT_W        = $clog2(SECTORS + 1);
    localparam int SPAN_W       = 9;
    localparam int RANGE_W      = 16;
    localparam int ADDR_W       = 5;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;
    localparam int ANG_W        = 26;
    localparam int CX_W         = 29;
    localparam int ROOT_W       = 35;

    localparam logic [RANGE_W-1:0] EMPTY_RANGE = 16'hFFFF;
    localparam logic [RANGE_W-1:0] MAX_H       = 16'd65534;
    localparam logic [RANGE_W-1:0] MIN_H       = 16'd100;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd4194304;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POINT = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_MIN_RANGE  = 3'd0,
        REG_MAX_RANGE  = 3'd1,
        REG_H_ABOVE    = 3'd2,
        REG_H_BELOW    = 3'd3,
        REG_INFLATION  = 3'd4,
        REG_OFFSET_X   = 3'd5,
        REG_OFFSET_Y   = 3'd6,
        REG_OFFSET_Z   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_POINT,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SEC_W-1:0]   center;
        logic [SPAN_W-1:0]  span;
        logic [RANGE_W-1:0] h;
    } cmd_t;

    typedef struct packed {
        logic [14:0]        min_range_mm;
        logic [14:0]        max_range_mm;
        logic [14:0]        height_above_mm;
        logic [14:0]        height_below_mm;
        logic [14:0]        inflation_radius_mm;
        logic signed [15:0] mount_offset_x_mm;
        logic signed [15:0] mount_offset_y_mm;
        logic signed [15:0] mount_offset_z_mm;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_SUM,
        F_CHK,
        F_ROOT,
        F_SPAN,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_RES
    } back_state_t;

    // arctan(2^-i) in 2^24 units per turn
    function automatic logic [21:0] atan_of(input logic [STEP_W-1:0] step);
        logic [21:0] v;
        case (step)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Heading (65536 per turn) to sector, clamped at both ends.
    function automatic logic [SEC_W-1:0] sector_of(input logic signed [17:0] hd);
        logic signed [18:0] sh;
        logic [16:0]        shc;
        logic [25:0]        prod;
        logic [25:0]        idx;
        sh = 19'(hd) + 19'sd32768;
        if (sh < 0)
        begin
            shc = '0;
        end
        else if (sh > 19'sd65536)
        begin
            shc = 17'd65536;
        end
        else
        begin
            shc = sh[16:0];
        end
        prod = 26'(shc) * 26'(SECTORS);
        idx  = prod >> 16;
        if (idx >= 26'(SECTORS))
        begin
            idx = 26'(SECTORS - 1);
        end
        return idx[SEC_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/poh_if.sv
// Valid/ready channel interfaces for input words and result words.
interface poh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] point_x_mm;
    logic [15:0] point_y_mm;
    logic [15:0] point_z_mm;
    logic        point_finite;
    logic [15:0] query_heading;
    logic [14:0] query_half_angle;

    modport source (output valid, operation, point_x_mm, point_y_mm, point_z_mm,
                    point_finite, query_heading, query_half_angle, input ready);
    modport sink   (input valid, operation, point_x_mm, point_y_mm, point_z_mm,
                    point_finite, query_heading, query_half_angle, output ready);
endinterface

interface poh_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] corridor_clearance_mm;
    logic [7:0]  center_sector;

    modport source (output valid, corridor_clearance_mm, center_sector, input ready);
    modport sink   (input valid, corridor_clearance_mm, center_sector, output ready);
endinterface

FILE: hw/rtl/poh_cordic.sv
// Iterative vectoring CORDIC, one micro-rotation per cycle.
module poh_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [17:0]            x_in,
    input  logic signed [17:0]            y_in,
    output logic                          done,
    output logic signed [poh_pkg::ANG_W-1:0] angle
);
    import poh_pkg::*;

    logic signed [CX_W-1:0]  cx_reg, cy_reg;
    logic signed [ANG_W-1:0] cz_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    run_reg, done_reg;

    logic signed [CX_W-1:0]  xs, ys, dx, dy;
    logic signed [ANG_W-1:0] at;

    always_comb
    begin
        xs = CX_W'(x_in) <<< 8;
        ys = CX_W'(y_in) <<< 8;
        dx = cy_reg >>> step_reg;
        dy = cx_reg >>> step_reg;
        at = signed'(ANG_W'(atan_of(step_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // pre-rotate the left half plane by a quarter turn
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    cx_reg <= ys;
                    cy_reg <= -xs;
                    cz_reg <= QUARTER_TURN;
                end
                else
                begin
                    cx_reg <= -ys;
                    cy_reg <= xs;
                    cz_reg <= -QUARTER_TURN;
                end
            end
            else
            begin
                cx_reg <= xs;
                cy_reg <= ys;
                cz_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - at;
            end
        end
    end

    assign done  = done_reg;
    assign angle = cz_reg;

endmodule

FILE: hw/rtl/poh_front.sv
// Front end: accepts words, filters points, finds sector, range and span.
module poh_front (
    input  logic              clk,
    input  logic              rst_n,
    poh_in_if.sink            req,
    input  poh_pkg::cfg_t      cfg,
    input  poh_pkg::q_status_t q_stat,
    output logic              q_push,
    output poh_pkg::cmd_t      q_cmd
);
    import poh_pkg::*;

    front_state_t state_reg, state_next;

    logic signed [17:0] x_reg, y_reg, z_reg;
    logic [33:0]        xx_reg, yy_reg, zz_reg;
    logic [29:0]        mn2_reg, mx2_reg;
    logic [ROOT_W-1:0]  h2_reg, d2_reg;
    logic [ROOT_W-1:0]  rv_reg, rr_reg, rbit_reg;
    logic [24:0]        a_reg;
    cmd_t               cmd_reg;

    logic                    cordic_start, cordic_done;
    logic signed [17:0]      cx, cy;
    logic signed [ANG_W-1:0] angle;

    logic                    drop;
    logic [RANGE_W-1:0]      h_val, hm;
    logic signed [ANG_W-1:0] zr;
    logic signed [17:0]      hd;
    logic [ROOT_W-1:0]       rsum;
    logic [24:0]             qprod;
    logic [34:0]             pprod;
    op_t                     op;

    poh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (cx),
        .y_in  (cy),
        .done  (cordic_done),
        .angle (angle)
    );

    always_comb
    begin
        op    = op_t'(req.operation);
        drop  = (d2_reg < ROOT_W'(mn2_reg)) || (d2_reg > ROOT_W'(mx2_reg)) ||
                (h2_reg == '0) ||
                (z_reg < -signed'(18'(cfg.height_above_mm))) ||
                (z_reg > signed'(18'(cfg.height_below_mm)));
        h_val = (rr_reg > ROOT_W'(MAX_H)) ? MAX_H : rr_reg[RANGE_W-1:0];
        hm    = (h_val < MIN_H) ? MIN_H : h_val;
        zr    = angle + ANG_W'(128);
        hd    = 18'(zr >>> 8);
        rsum  = rr_reg + rbit_reg;
        qprod = 25'(req.query_half_angle) * 25'(SECTORS) + 25'(16'hFFFF);
        pprod = 35'(a_reg) * 35'(SECTORS) + 35'(24'hFFFFFF);
    end

    always_comb
    begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        cx           = '0;
        cy           = '0;
        q_push       = 1'b0;
        req.ready    = (state_reg == F_IDLE);
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    case (op)
                        OP_CLEAR, OP_QUERY: state_next = F_PUSH;
                        OP_POINT:
                        begin
                            if (req.point_finite)
                            begin
                                state_next = F_SQ;
                            end
                        end
                        default: state_next = F_IDLE;
                    endcase
                end
            end
            F_SQ:  state_next = F_SUM;
            F_SUM: state_next = F_CHK;
            F_CHK:
            begin
                if (drop)
                begin
                    state_next = F_IDLE;
                end
                else
                begin
                    cordic_start = 1'b1;
                    cx           = x_reg;
                    cy           = y_reg;
                    state_next   = F_ROOT;
                end
            end
            F_ROOT:
            begin
                // square root settles before the heading CORDIC reports done
                if (cordic_done)
                begin
                    if (cfg.inflation_radius_mm == '0)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        cordic_start = 1'b1;
                        cx           = signed'(18'(hm));
                        cy           = signed'(18'(cfg.inflation_radius_mm));
                        state_next   = F_SPAN;
                    end
                end
            end
            F_SPAN:
            begin
                if (cordic_done)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC: state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    x_reg <= 18'(signed'(req.point_x_mm)) + 18'(cfg.mount_offset_x_mm);
                    y_reg <= 18'(signed'(req.point_y_mm)) + 18'(cfg.mount_offset_y_mm);
                    z_reg <= 18'(signed'(req.point_z_mm)) + 18'(cfg.mount_offset_z_mm);
                    cmd_reg.kind   <= (op == OP_CLEAR) ? CMD_CLEAR : CMD_QUERY;
                    cmd_reg.center <= sector_of(18'(signed'(req.query_heading)));
                    cmd_reg.span   <= SPAN_W'(qprod >> 16);
                    cmd_reg.h      <= '0;
                end
            end
            F_SQ:
            begin
                xx_reg  <= 34'(36'(x_reg) * 36'(x_reg));
                yy_reg  <= 34'(36'(y_reg) * 36'(y_reg));
                zz_reg  <= 34'(36'(z_reg) * 36'(z_reg));
                mn2_reg <= 30'(cfg.min_range_mm) * 30'(cfg.min_range_mm);
                mx2_reg <= 30'(cfg.max_range_mm) * 30'(cfg.max_range_mm);
            end
            F_SUM:
            begin
                h2_reg <= ROOT_W'(xx_reg) + ROOT_W'(yy_reg);
                d2_reg <= ROOT_W'(xx_reg) + ROOT_W'(yy_reg) + ROOT_W'(zz_reg);
            end
            F_CHK:
            begin
                rv_reg   <= h2_reg;
                rr_reg   <= '0;
                rbit_reg <= ROOT_W'(1) << 32;
            end
            F_ROOT:
            begin
                // restoring square root, one result bit per cycle
                if (rbit_reg != '0)
                begin
                    if (rv_reg >= rsum)
                    begin
                        rv_reg <= rv_reg - rsum;
                        rr_reg <= (rr_reg >> 1) + rbit_reg;
                    end
                    else
                    begin
                        rr_reg <= rr_reg >> 1;
                    end
                    rbit_reg <= rbit_reg >> 2;
                end
                if (cordic_done)
                begin
                    cmd_reg.kind   <= CMD_POINT;
                    cmd_reg.center <= sector_of(hd);
                    cmd_reg.span   <= '0;
                    cmd_reg.h      <= h_val;
                end
            end
            F_SPAN:
            begin
                if (cordic_done)
                begin
                    a_reg <= (angle < 0) ? '0 : angle[24:0];
                end
            end
            F_CALC:
            begin
                cmd_reg.span <= SPAN_W'(pprod >> 24);
            end
            default:
            begin
            end
        endcase
    end

    assign q_cmd = cmd_reg;

endmodule

FILE: hw/rtl/poh_queue.sv
// Two-entry command queue between front and back ends.
module poh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  poh_pkg::cmd_t       push_cmd,
    input  logic               pop,
    output poh_pkg::cmd_t       head,
    output poh_pkg::q_status_t  stat
);
    import poh_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = ent_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

FILE: hw/rtl/poh_back.sv
// Back end: sector store, clears, min-update walk for points, min search for queries.
`include "polar_obstacle_histogram_defines.svh"
module poh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  poh_pkg::cmd_t       cmd,
    input  poh_pkg::q_status_t  q_stat,
    output logic               q_pop,
    poh_out_if.source          rsp
);
    import poh_pkg::*;

    back_state_t state_reg, state_next;

    logic [RANGE_W-1:0] mem [SECTORS];
    logic [SECTORS-1:0] valid_reg, valid_next;
    logic [RANGE_W-1:0] rd_data_reg;
    logic               rd_ok_reg;
    logic               rd_pend_reg, rd_pend_next;
    logic [SEC_W-1:0]   wr_addr_reg;
    logic [SEC_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    cmd_kind_t          kind_reg, kind_next;
    logic [RANGE_W-1:0] h_reg, h_next;
    logic [SEC_W-1:0]   center_reg, center_next;
    logic [RANGE_W-1:0] best_reg, best_next;
    logic               out_valid_reg, out_valid_next;
    logic [RANGE_W-1:0] out_range_reg;
    logic [SEC_W-1:0]   out_center_reg;

    logic               wr_en, out_load;
    logic [RANGE_W-1:0] cur;
    logic [SPAN_W:0]    start_raw;
    logic [SPAN_W:0]    walk_len;
    logic [SEC_W-1:0]   start;
    logic [CNT_W-1:0]   cnt;

    always_comb
    begin
        cur       = rd_ok_reg ? rd_data_reg : EMPTY_RANGE;
        start_raw = (SPAN_W+1)'(cmd.center) + (SPAN_W+1)'(SECTORS) - (SPAN_W+1)'(cmd.span);
        if (start_raw >= (SPAN_W+1)'(SECTORS))
        begin
            start_raw = start_raw - (SPAN_W+1)'(SECTORS);
        end
        // a full-circle walk ignores the start, so any wrap leftover is harmless
        start    = (start_raw >= (SPAN_W+1)'(SECTORS)) ? '0 : start_raw[SEC_W-1:0];
        walk_len = {cmd.span, 1'b1};
        cnt      = (walk_len >= (SPAN_W+1)'(SECTORS)) ? CNT_W'(SECTORS) : CNT_W'(walk_len);
    end

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        addr_next    = addr_reg;
        left_next    = left_reg;
        rd_pend_next = 1'b0;
        valid_next   = valid_reg;
        best_next    = best_reg;
        kind_next    = kind_reg;
        h_next       = h_reg;
        center_next  = center_reg;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    if (cmd.kind == CMD_CLEAR)
                    begin
                        valid_next = '0;
                    end
                    else
                    begin
                        kind_next   = cmd.kind;
                        h_next      = cmd.h;
                        center_next = cmd.center;
                        addr_next   = start;
                        left_next   = cnt;
                        best_next   = EMPTY_RANGE;
                        state_next  = B_WALK;
                    end
                end
            end
            B_WALK:
            begin
                if (left_reg != '0)
                begin
                    rd_pend_next = 1'b1;
                    left_next    = left_reg - 1'b1;
                    addr_next    = (addr_reg == SEC_W'(SECTORS - 1)) ? '0 : addr_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (kind_reg == CMD_POINT && cur > h_reg)
                    begin
                        wr_en                   = 1'b1;
                        valid_next[wr_addr_reg] = 1'b1;
                    end
                    if (kind_reg == CMD_QUERY && cur < best_reg)
                    begin
                        best_next = cur;
                    end
                end
                if (left_reg == '0 && !rd_pend_reg)
                begin
                    state_next = (kind_reg == CMD_QUERY) ? B_RES : B_IDLE;
                end
            end
            B_RES:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rd_pend_reg   <= rd_pend_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        kind_reg    <= kind_next;
        h_reg       <= h_next;
        center_reg  <= center_next;
        best_reg    <= best_next;
        rd_data_reg <= mem[addr_reg];
        rd_ok_reg   <= valid_reg[addr_reg];
        wr_addr_reg <= addr_reg;
        if (wr_en)
        begin
            mem[wr_addr_reg] <= h_reg;
        end
        if (out_load)
        begin
            out_range_reg  <= best_reg;
            out_center_reg <= center_reg;
        end
    end

    assign rsp.valid                 = out_valid_reg;
    assign rsp.corridor_clearance_mm = out_range_reg;
    assign rsp.center_sector         = 8'(out_center_reg);

    `POH_ASSERT(a_out_from_res, $rose(out_valid_reg) |-> $past(state_reg == B_RES), "result without search")
    `POH_ASSERT(a_clear_empties, (q_pop && cmd.kind == CMD_CLEAR) |=> (valid_reg == '0), "clear missed")
    `POH_ASSERT(a_pend_in_walk, rd_pend_reg |-> $past(state_reg == B_WALK), "stray read")
    `POH_NEVER(a_left_bound, left_reg > CNT_W'(SECTORS), "walk longer than store")

endmodule

FILE: hw/rtl/polar_obstacle_histogram.sv
// Front: clear and query words go straight to F_PUSH; a point word is squared, summed and
// range-checked, then runs the heading CORDIC with the 17-step root beside it, then the span
// CORDIC unless inflation is off; filtered points end at the check, non-finite ones at once.
// Back end: a pop, 2*span+1 sector reads (capped at SECTORS), then a result for queries.
// The front takes a new word only once idle again; F_PUSH waits while the queue is full.
// Reset (rst_n, async low) empties every sector via per-sector valid bits, loads reg resets.
module polar_obstacle_histogram (
    input  logic                       clk,
    input  logic                       rst_n,
    poh_in_if.sink                     req,
    poh_out_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [poh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import poh_pkg::*;

    // Configuration registers, APB word per register at 4*index.
    cfg_t      cfg_reg;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    // Command queue between the classifying front and the sector-walking back.
    cmd_t      q_in_cmd, q_head;
    logic      q_push, q_pop;
    q_status_t q_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_range_mm        <= 15'd600;
            cfg_reg.max_range_mm        <= 15'd25000;
            cfg_reg.height_above_mm     <= 15'd1000;
            cfg_reg.height_below_mm     <= 15'd1400;
            cfg_reg.inflation_radius_mm <= 15'd1000;
            cfg_reg.mount_offset_x_mm   <= '0;
            cfg_reg.mount_offset_y_mm   <= '0;
            cfg_reg.mount_offset_z_mm   <= -16'sd50;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MIN_RANGE: cfg_reg.min_range_mm        <= pwdata[14:0];
                REG_MAX_RANGE: cfg_reg.max_range_mm        <= pwdata[14:0];
                REG_H_ABOVE:   cfg_reg.height_above_mm     <= pwdata[14:0];
                REG_H_BELOW:   cfg_reg.height_below_mm     <= pwdata[14:0];
                REG_INFLATION: cfg_reg.inflation_radius_mm <= pwdata[14:0];
                REG_OFFSET_X:  cfg_reg.mount_offset_x_mm   <= signed'(pwdata[15:0]);
                REG_OFFSET_Y:  cfg_reg.mount_offset_y_mm   <= signed'(pwdata[15:0]);
                REG_OFFSET_Z:  cfg_reg.mount_offset_z_mm   <= signed'(pwdata[15:0]);
                default:
                begin
                end
            endcase
        end
    end

    // Read-back mux; unsigned fields zero-extend, offsets read as 16-bit words.
    always_comb
    begin
        case (cfg_idx)
            REG_MIN_RANGE: prdata = 32'(cfg_reg.min_range_mm);
            REG_MAX_RANGE: prdata = 32'(cfg_reg.max_range_mm);
            REG_H_ABOVE:   prdata = 32'(cfg_reg.height_above_mm);
            REG_H_BELOW:   prdata = 32'(cfg_reg.height_below_mm);
            REG_INFLATION: prdata = 32'(cfg_reg.inflation_radius_mm);
            REG_OFFSET_X:  prdata = 32'(unsigned'(cfg_reg.mount_offset_x_mm));
            REG_OFFSET_Y:  prdata = 32'(unsigned'(cfg_reg.mount_offset_y_mm));
            REG_OFFSET_Z:  prdata = 32'(unsigned'(cfg_reg.mount_offset_z_mm));
            default:       prdata = '0;
        endcase
    end

    // Front: takes input words, filters points, computes heading sector,
    // horizontal range and inflation span, and posts one command per word it keeps.
    poh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_cmd  (q_in_cmd)
    );

    poh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // Back: owns the sector store and the result register, so a finished
    // result waits there while the front keeps taking words until the queue fills.
    poh_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .rsp    (rsp)
    );

endmodule

FILE: bench/poh_checker.sv
// Checker for the polar histogram: tracks config writes, predicts corridor answers, compares.
module poh_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    poh_in_if                          req,
    poh_out_if                         rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [poh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         fails,
    output int                         pending
);
    import poh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TURN_Q = 4194304;
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20
    };

    typedef struct {
        logic [15:0] clearance;
        logic [7:0]  sector;
    } corridor_t;

    corridor_t   corridor_q[$];
    logic [15:0] sector_range [SECTORS];
    cfg_t        cfg;

    // angle of (x, y), 2^24 units per turn
    function automatic longint angle_of(longint xi, longint yi);
        longint x, y, z, t, dx, dy;
        x = xi * 256;
        y = yi * 256;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = TURN_Q;
            end
            else
            begin
                t = x; x = -y; y = t; z = -TURN_Q;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += ATAN_STEP[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic int heading_sector(longint hd);
        longint sh;
        longint idx;
        sh = hd + 32768;
        if (sh < 0) sh = 0;
        if (sh > 65536) sh = 65536;
        idx = (sh * SECTORS) >>> 16;
        if (idx >= SECTORS) idx = SECTORS - 1;
        return int'(idx);
    endfunction

    function automatic longint root_of(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 262144;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // min-write one lidar point into the histogram
    task automatic mark_obstacle(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        longint x, y, z, h2, d2, h, hm, a, span;
        int center, s;
        x = longint'($signed(px)) + longint'(cfg.mount_offset_x_mm);
        y = longint'($signed(py)) + longint'(cfg.mount_offset_y_mm);
        z = longint'($signed(pz)) + longint'(cfg.mount_offset_z_mm);
        h2 = x * x + y * y;
        d2 = h2 + z * z;
        if (d2 < longint'(cfg.min_range_mm) * longint'(cfg.min_range_mm)) return;
        if (d2 > longint'(cfg.max_range_mm) * longint'(cfg.max_range_mm)) return;
        if (h2 == 0) return;
        if (z < -longint'(cfg.height_above_mm) || z > longint'(cfg.height_below_mm)) return;
        h = root_of(h2);
        if (h > 65534) h = 65534;
        center = heading_sector((angle_of(x, y) + 128) >>> 8);
        hm = (h < 100) ? 100 : h;
        if (cfg.inflation_radius_mm == 0)
            span = 0;
        else
        begin
            a = angle_of(hm, longint'(cfg.inflation_radius_mm));
            if (a < 0) a = 0;
            span = (a * SECTORS + 16777215) >>> 24;
        end
        for (longint k = -span; k <= span; k++)
        begin
            s = int'(((center + k) % SECTORS + SECTORS) % SECTORS);
            if (sector_range[s] > h[15:0]) sector_range[s] = h[15:0];
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        corridor_t c;
        longint span, best;
        int center, s;
        if (!rst_n)
        begin
            foreach (sector_range[i]) sector_range[i] = EMPTY_RANGE;
            cfg = '{min_range_mm: 15'd600, max_range_mm: 15'd25000,
                    height_above_mm: 15'd1000, height_below_mm: 15'd1400,
                    inflation_radius_mm: 15'd1000, mount_offset_x_mm: 16'sd0,
                    mount_offset_y_mm: 16'sd0, mount_offset_z_mm: -16'sd50};
            corridor_q.delete();
            fails = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_MIN_RANGE: cfg.min_range_mm        = pwdata[14:0];
                    REG_MAX_RANGE: cfg.max_range_mm        = pwdata[14:0];
                    REG_H_ABOVE:   cfg.height_above_mm     = pwdata[14:0];
                    REG_H_BELOW:   cfg.height_below_mm     = pwdata[14:0];
                    REG_INFLATION: cfg.inflation_radius_mm = pwdata[14:0];
                    REG_OFFSET_X:  cfg.mount_offset_x_mm   = pwdata[15:0];
                    REG_OFFSET_Y:  cfg.mount_offset_y_mm   = pwdata[15:0];
                    REG_OFFSET_Z:  cfg.mount_offset_z_mm   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (corridor_q.size() == 0)
                    report("unexpected word", rsp.corridor_clearance_mm, 0);
                else
                begin
                    c = corridor_q.pop_front();
                    if (rsp.corridor_clearance_mm !== c.clearance)
                        report("clearance", rsp.corridor_clearance_mm, c.clearance);
                    if (rsp.center_sector !== c.sector)
                        report("center_sector", rsp.center_sector, c.sector);
                end
            end
            if (req.valid && req.ready)
            begin
                case (op_t'(req.operation))
                    OP_CLEAR: foreach (sector_range[i]) sector_range[i] = EMPTY_RANGE;
                    OP_POINT:
                        if (req.point_finite)
                            mark_obstacle(req.point_x_mm, req.point_y_mm, req.point_z_mm);
                    OP_QUERY:
                    begin
                        center = heading_sector(longint'($signed(req.query_heading)));
                        span = (longint'(req.query_half_angle) * SECTORS + 65535) >>> 16;
                        best = EMPTY_RANGE;
                        for (longint k = -span; k <= span; k++)
                        begin
                            s = int'(((center + k) % SECTORS + SECTORS) % SECTORS);
                            if (sector_range[s] < best) best = sector_range[s];
                        end
                        c.clearance = best[15:0];
                        c.sector    = center[7:0];
                        corridor_q.push_back(c);
                    end
                    default: ;
                endcase
            end
        end
        pending = corridor_q.size();
    end
endmodule

FILE: bench/tb.sv
// Top of the polar histogram bench: clock, reset, config phases, word stimulus, verdict.
module tb;
    import poh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fails;
    int                pending;
    bit                calm = 1'b0;    // no idling on either side
    int                ready_hold = 0;
    bit                ready_level = 1'b1;

    poh_in_if  req ();
    poh_out_if rsp ();

    polar_obstacle_histogram i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    poh_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .fails   (fails),
        .pending (pending)
    );

    always #4 clk = ~clk;

    // result side: random stall bursts between ready stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (calm)
            rsp.ready <= 1'b1;
        else
        begin
            if (ready_hold == 0)
            begin
                ready_level = ($urandom_range(0, 2) != 0);
                ready_hold  = ready_level ? $urandom_range(1, 30) : $urandom_range(1, 8);
            end
            ready_hold--;
            rsp.ready <= ready_level;
        end
    end

    // APB write: setup cycle, then access until pready
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(int mn, int mx, int ha, int hb, int infl, int ox, int oy, int oz);
        write_reg(REG_MIN_RANGE, mn);
        write_reg(REG_MAX_RANGE, mx);
        write_reg(REG_H_ABOVE, ha);
        write_reg(REG_H_BELOW, hb);
        write_reg(REG_INFLATION, infl);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
    endtask

    // one word on the request channel, optionally after a gap
    task automatic send_word(op_t op, int x, int y, int z, bit fin, int hd, int half);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req.valid            <= 1'b1;
        req.operation        <= op;
        req.point_x_mm       <= x[15:0];
        req.point_y_mm       <= y[15:0];
        req.point_z_mm       <= z[15:0];
        req.point_finite     <= fin;
        req.query_heading    <= hd[15:0];
        req.query_half_angle <= half[14:0];
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic send_point(int x, int y, int z);
        send_word(OP_POINT, x, y, z, 1'b1, $urandom, $urandom);
    endtask

    task automatic send_query(int hd, int half);
        send_word(OP_QUERY, $urandom, $urandom, $urandom, $urandom, hd, half);
    endtask

    // pause until every answer is back and the point pipeline has drained
    task automatic drain();
        req.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_words(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                // mostly plausible points inside the band
                send_point(int'($urandom_range(0, 40000)) - 20000,
                           int'($urandom_range(0, 40000)) - 20000,
                           int'($urandom_range(0, 3000)) - 1400);
            else if (r < 62)
                send_word(OP_POINT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 90)
                send_query($urandom, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                                  : $urandom_range(0, 16384));
            else if (r < 93)
                send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 95)
                send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_point(int'($urandom_range(0, 1200)) - 600,
                           int'($urandom_range(0, 1200)) - 600,
                           int'($urandom_range(0, 400)) - 200);
        end
    endtask

    initial
    begin
        req.valid            = 1'b0;
        req.operation        = OP_CLEAR;
        req.point_x_mm       = '0;
        req.point_y_mm       = '0;
        req.point_z_mm       = '0;
        req.point_finite     = 1'b0;
        req.query_heading    = '0;
        req.query_half_angle = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: reset values, directed corner words
        load_config(600, 25000, 1000, 1400, 1000, 0, 0, -50);
        send_query(0, 16384);                 // empty histogram answers 65535
        send_point(-2000, 0, 0);              // exactly behind, last sector
        send_point(-2000, -1, 0);
        send_point(3000, 3000, 100);
        send_point(32767, 32767, 0);          // beyond max range
        send_point(100, 100, 0);              // too near
        send_point(0, 0, 1000);               // no horizontal distance
        send_point(2000, 0, 32767);           // below the band
        send_point(2000, 0, -32768);          // above the band
        send_word(OP_POINT, 1500, 0, 0, 1'b0, 0, 0);   // non-finite
        send_word(OP_NONE, -1, -1, -1, 1'b1, -1, 32767);
        send_query(-32768, 0);
        send_query(32767, 0);
        send_query(32767, 16384);
        send_query(-32768, 32767);            // span wider than the histogram
        send_query(0, 1);
        send_word(OP_CLEAR, 0, 0, 0, 1'b0, 0, 0);
        send_query(0, 32767);
        random_words(180);
        drain();

        // phase 2: widest band, largest inflation, max offsets
        load_config(50, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_word(OP_CLEAR, 0, 0, 0, 1'b0, 0, 0);
        random_words(180);
        drain();

        // phase 3: min above max drops every point; inflation off
        load_config(32767, 550, 0, 0, 0, -32768, -32768, -32768);
        random_words(120);
        drain();

        // phase 4: zero inflation, zero offsets, band only at and below the mount
        load_config(50, 32767, 0, 32767, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 1'b0, 0, 0);
        random_words(180);
        drain();

        // phase 5: random in-range settings
        load_config($urandom_range(50, 2000), $urandom_range(8000, 32767),
                    $urandom_range(0, 32767), $urandom_range(0, 32767),
                    $urandom_range(100, 32767), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        send_word(OP_CLEAR, 0, 0, 0, 1'b0, 0, 0);
        random_words(250);
        drain();

        // last phase: reset ranges and heights, small inflation and offsets, with no idling at all
        calm = 1'b1;
        load_config(600, 25000, 1000, 1400, 100, -100, 100, -50);
        random_words(220);
        drain();

        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
